// ----- design/lnps_pkg.sv -----
// Package for the last-note priority stack.
// Holds field widths, the note limit, the command codes and the sequencer states.
// No dependencies.
package lnps_pkg;

  localparam int unsigned NOTE_W  = 5;
  localparam int unsigned COUNT_W = 4;

  // Note indices at or above this value are not notes.
  localparam logic [NOTE_W-1:0] NOTE_LIMIT = 5'd24;

  typedef enum logic {
    CMD_PRESS   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PUSH,
    ST_RDTOP,
    ST_TOPCAP,
    ST_FIN
  } state_e;

endpackage

// ----- design/lnps_in_if.sv -----
// Input channel of the last-note priority stack: one key event per beat.
// Depends on lnps_pkg for the field widths.
interface lnps_in_if;
  import lnps_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [NOTE_W-1:0] note;

  modport source (output valid, output command, output note, input ready);
  modport sink   (input valid, input command, input note, output ready);

endinterface

// ----- design/lnps_out_if.sv -----
// Output channel of the last-note priority stack: top of stack and count per beat.
// Depends on lnps_pkg for the field widths.
interface lnps_out_if;
  import lnps_pkg::*;

  logic               valid;
  logic               ready;
  logic               top_valid;
  logic [NOTE_W-1:0]  top_note;
  logic [COUNT_W-1:0] held_count;

  modport source (output valid, output top_valid, output top_note, output held_count,
                  input ready);
  modport sink   (input valid, input top_valid, input top_note, input held_count,
                  output ready);

endinterface

// ----- design/last_note_priority_stack_core.sv -----
// Last-note priority stack for a monophonic synthesizer.
// Depends on lnps_pkg, lnps_in_if and lnps_out_if.
//
// Usage: in_chan_i carries one key event per beat (command 0 = press,
// 1 = release, plus a note index). For every accepted beat, out_chan_o
// delivers one beat with the most recently pushed held note, a flag that
// says whether any note is held, and the number of held notes.
// The held notes live in a small memory with one read and one write port,
// oldest at address 0. A sequencer walks it one entry per cycle: a search
// for the note, then, where needed, a move of the entries above a gap (or
// of all entries above the oldest when a full stack drops it), then a
// push or a reread of the new top. An index that is not a note goes
// straight to the result. The result beat appears in the same cycle that
// the sequencer returns to idle. in_chan_i.ready is high only while the
// sequencer is idle. Results sit in an output register, so a new event is
// taken while the previous result still waits; if the receiver stalls, a
// finished result waits in the sequencer until the register frees. Reset
// empties the stack and drops any pending result; the memory itself is
// not cleared.
module last_note_priority_stack_core #(
  parameter int unsigned STACK_DEPTH = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  lnps_in_if.sink    in_chan_i,
  lnps_out_if.source out_chan_o
);
  import lnps_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [AW-1:0] TOP_ADDR = AW'(STACK_DEPTH - 1);

  state_e state_q, state_d;

  logic              cmd_q, cmd_d;
  logic [NOTE_W-1:0] note_q, note_d;
  logic [CW-1:0]     count_q, count_d;
  logic [NOTE_W-1:0] top_q, top_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     end_q, end_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_idx_q, pend_idx_d;

  logic               out_valid_q, out_valid_d;
  logic               out_top_valid_q, out_top_valid_d;
  logic [NOTE_W-1:0]  out_top_note_q, out_top_note_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic [NOTE_W-1:0] mem [STACK_DEPTH];
  logic [NOTE_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr;
  logic              rd_issue;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [NOTE_W-1:0] wr_data;

  logic          in_fire;
  logic          hit;
  logic          scan_done;
  logic          shift_done;
  logic          pos_is_top;
  logic          out_free;
  logic [CW-1:0] count_m1;

  assign in_chan_i.ready = (state_q == ST_IDLE);
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;

  assign count_m1   = count_q - CW'(1);
  assign hit        = pend_q && (rd_data_q == note_q);
  assign scan_done  = !pend_q && (ptr_q >= count_q);
  assign shift_done = !pend_q && (ptr_q >= end_q);
  assign pos_is_top = (CW'(pend_idx_q) == count_m1);
  assign out_free   = !out_valid_q || out_chan_o.ready;

  // Note memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_chan_i.note >= NOTE_LIMIT) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (cmd_q == CMD_PRESS) begin
            state_d = ST_FIN;
          end else if (pos_is_top) begin
            state_d = (count_q >= CW'(2)) ? ST_RDTOP : ST_FIN;
          end else begin
            state_d = ST_SHIFT;
          end
        end else if (scan_done) begin
          if (cmd_q == CMD_RELEASE) begin
            state_d = ST_FIN;
          end else if (count_q == DEPTH_C) begin
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_SHIFT: begin
        if (shift_done) begin
          state_d = (cmd_q == CMD_PRESS) ? ST_PUSH : ST_FIN;
        end
      end
      ST_PUSH:   state_d = ST_FIN;
      ST_RDTOP:  state_d = ST_TOPCAP;
      ST_TOPCAP: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_issue = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = pend_idx_q - AW'(1);
    wr_data  = rd_data_q;
    unique case (state_q)
      ST_SCAN: begin
        rd_issue = !hit && (ptr_q < count_q);
      end
      ST_SHIFT: begin
        rd_issue = (ptr_q < end_q);
        // Each entry read in the previous cycle lands one place lower.
        wr_en    = pend_q;
      end
      ST_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = (count_q == DEPTH_C) ? TOP_ADDR : count_q[AW-1:0];
        wr_data = note_q;
      end
      ST_RDTOP: begin
        rd_addr = count_m1[AW-1:0];
      end
      ST_IDLE, ST_TOPCAP, ST_FIN: begin
      end
      default: begin
      end
    endcase
    if (rd_issue) begin
      rd_addr = ptr_q[AW-1:0];
    end
  end

  // Datapath registers.
  always_comb begin
    cmd_d      = cmd_q;
    note_d     = note_q;
    count_d    = count_q;
    top_d      = top_q;
    ptr_d      = rd_issue ? ptr_q + CW'(1) : ptr_q;
    end_d      = end_q;
    pend_d     = rd_issue;
    pend_idx_d = rd_issue ? ptr_q[AW-1:0] : pend_idx_q;

    out_valid_d     = out_valid_q && !out_chan_o.ready;
    out_top_valid_d = out_top_valid_q;
    out_top_note_d  = out_top_note_q;
    out_count_d     = out_count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d  = in_chan_i.command;
          note_d = in_chan_i.note;
          ptr_d  = '0;
        end
      end
      ST_SCAN: begin
        if (hit && (cmd_q == CMD_RELEASE)) begin
          if (pos_is_top) begin
            count_d = count_m1;
          end else begin
            ptr_d = CW'(pend_idx_q) + CW'(1);
            end_d = count_q;
          end
        end else if (scan_done && (cmd_q == CMD_PRESS) && (count_q == DEPTH_C)) begin
          // Full stack: the oldest entry goes, everything above it moves down.
          ptr_d = CW'(1);
          end_d = DEPTH_C;
        end
      end
      ST_SHIFT: begin
        if (shift_done && (cmd_q == CMD_RELEASE)) begin
          count_d = count_m1;
        end
      end
      ST_PUSH: begin
        top_d = note_q;
        if (count_q != DEPTH_C) begin
          count_d = count_q + CW'(1);
        end
      end
      ST_TOPCAP: begin
        top_d = rd_data_q;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_top_valid_d = (count_q != '0);
          out_top_note_d  = (count_q != '0) ? top_q : '0;
          out_count_d     = COUNT_W'(count_q);
        end
      end
      ST_RDTOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q           <= cmd_d;
    note_q          <= note_d;
    top_q           <= top_d;
    ptr_q           <= ptr_d;
    end_q           <= end_d;
    pend_idx_q      <= pend_idx_d;
    out_top_valid_q <= out_top_valid_d;
    out_top_note_q  <= out_top_note_d;
    out_count_q     <= out_count_d;
  end

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.top_valid  = out_top_valid_q;
  assign out_chan_o.top_note   = out_top_note_q;
  assign out_chan_o.held_count = out_count_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("held count exceeds the stack depth");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FIN) |-> !wr_en)
    else $error("note memory written outside an event");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_chan_i.ready)
    else $error("input taken again before the event finished");

  a_result_follows_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> out_valid_q)
    else $error("finished event produced no result beat");

endmodule

// ----- verif/last_note_priority_stack_core_tb.sv -----
// Testbench for the last-note priority stack core: directed key events, then random ones.
// Result beats are checked against a model of the held-note stack or a hand-set result.
// Depends on lnps_pkg, lnps_in_if, lnps_out_if and last_note_priority_stack_core.
module last_note_priority_stack_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lnps_pkg::*;

  localparam int STACK_DEPTH  = 8;
  localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_EVENTS_PER_PHASE = 175;

  typedef struct packed {
    logic               top_valid;
    logic [NOTE_W-1:0]  top_note;
    logic [COUNT_W-1:0] held_count;
  } stack_view_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [NOTE_W-1:0] note;
    logic              fixed;
    stack_view_t       want;
  } key_row_t;

  localparam stack_view_t EMPTY_VIEW = '{1'b0, 5'd0, 4'd0};
  localparam stack_view_t ANY_VIEW   = '{1'b0, 5'd0, 4'd0};
  localparam int DIRECTED_ROWS = 25;

  // Rows marked fixed carry their result by hand; the others use the model.
  localparam key_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_RELEASE, 5'd5,  1'b1, EMPTY_VIEW},          // release on an empty stack
    '{CMD_PRESS,   5'd31, 1'b1, EMPTY_VIEW},          // not a note
    '{CMD_PRESS,   5'd24, 1'b1, EMPTY_VIEW},          // first index that is not a note
    '{CMD_PRESS,   5'd0,  1'b1, '{1'b1, 5'd0, 4'd1}},
    '{CMD_PRESS,   5'd0,  1'b1, '{1'b1, 5'd0, 4'd1}}, // already held, no move to top
    '{CMD_PRESS,   5'd23, 1'b1, '{1'b1, 5'd23, 4'd2}},
    '{CMD_PRESS,   5'd10, 1'b0, ANY_VIEW},
    '{CMD_PRESS,   5'd11, 1'b0, ANY_VIEW},
    '{CMD_PRESS,   5'd12, 1'b0, ANY_VIEW},
    '{CMD_PRESS,   5'd13, 1'b0, ANY_VIEW},
    '{CMD_PRESS,   5'd14, 1'b0, ANY_VIEW},
    '{CMD_PRESS,   5'd15, 1'b1, '{1'b1, 5'd15, 4'd8}}, // stack now full
    '{CMD_PRESS,   5'd16, 1'b0, ANY_VIEW},             // drops the oldest note
    '{CMD_PRESS,   5'd23, 1'b0, ANY_VIEW},             // held, not moved
    '{CMD_PRESS,   5'd0,  1'b0, ANY_VIEW},             // full again, drops 23
    '{CMD_RELEASE, 5'd28, 1'b0, ANY_VIEW},
    '{CMD_RELEASE, 5'd13, 1'b0, ANY_VIEW},             // gap in the middle
    '{CMD_RELEASE, 5'd0,  1'b0, ANY_VIEW},             // top note
    '{CMD_RELEASE, 5'd10, 1'b0, ANY_VIEW},             // oldest note
    '{CMD_RELEASE, 5'd20, 1'b0, ANY_VIEW},             // not held
    '{CMD_RELEASE, 5'd11, 1'b0, ANY_VIEW},
    '{CMD_RELEASE, 5'd12, 1'b0, ANY_VIEW},
    '{CMD_RELEASE, 5'd14, 1'b0, ANY_VIEW},
    '{CMD_RELEASE, 5'd15, 1'b0, ANY_VIEW},
    '{CMD_RELEASE, 5'd16, 1'b1, EMPTY_VIEW}
  };

  logic clk;
  logic rst_n;

  lnps_in_if  in_chan ();
  lnps_out_if out_chan ();

  last_note_priority_stack_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_chan_i (in_chan),
    .out_chan_o(out_chan)
  );

  // Model state of the held-note stack, oldest entry at index 0.
  logic [NOTE_W-1:0] held_stack [STACK_DEPTH];
  int                held_num;

  stack_view_t expected_views [$];
  int          error_count;
  int          events_sent;
  int          results_checked;
  int          full_drops;
  int          ignored_events;
  int          idle_pct;
  int          stall_pct;
  bit          hold_req;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic apply_key_event(input cmd_e cmd, input logic [NOTE_W-1:0] note,
                                 output stack_view_t view);
    int pos;
    pos = -1;
    for (int i = 0; i < held_num; i++) begin
      if (pos < 0 && held_stack[i] == note) pos = i;
    end
    if (cmd == CMD_PRESS) begin
      if (note < NOTE_LIMIT && pos < 0) begin
        if (held_num >= STACK_DEPTH) begin
          for (int i = 0; i + 1 < STACK_DEPTH; i++) held_stack[i] = held_stack[i+1];
          held_num = STACK_DEPTH - 1;
          full_drops++;
        end
        held_stack[held_num] = note;
        held_num++;
      end else begin
        ignored_events++;
      end
    end else if (pos >= 0) begin
      for (int i = pos; i + 1 < held_num; i++) held_stack[i] = held_stack[i+1];
      held_num--;
    end else begin
      ignored_events++;
    end
    view.top_valid  = (held_num > 0);
    view.top_note   = (held_num > 0) ? held_stack[held_num-1] : '0;
    view.held_count = COUNT_W'(held_num);
  endtask

  // Offers one key event, waits until the core takes it, then records the expected result.
  task automatic send_key_event(input cmd_e cmd, input logic [NOTE_W-1:0] note,
                                input logic fixed, input stack_view_t want);
    stack_view_t view;
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.command <= cmd;
    in_chan.note    <= note;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    apply_key_event(cmd, note, view);
    expected_views.push_back(fixed ? want : view);
    events_sent++;
  endtask

  // Result side: checks each beat and decides the next cycle's ready.
  initial begin
    stack_view_t want;
    int          hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result beat with nothing expected: valid %0b note %0d count %0d",
                   $time, out_chan.top_valid, out_chan.top_note, out_chan.held_count);
          error_count++;
        end else begin
          want = expected_views.pop_front();
          results_checked++;
          if (out_chan.top_valid !== want.top_valid) begin
            $display("%0t: top_valid expected %0b actual %0b",
                     $time, want.top_valid, out_chan.top_valid);
            error_count++;
          end
          if (out_chan.top_note !== want.top_note) begin
            $display("%0t: top_note expected %0d actual %0d",
                     $time, want.top_note, out_chan.top_note);
            error_count++;
          end
          if (out_chan.held_count !== want.held_count) begin
            $display("%0t: held_count expected %0d actual %0d",
                     $time, want.held_count, out_chan.held_count);
            error_count++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    cmd_e              cmd;
    logic [NOTE_W-1:0] note;
    int                r;
    int                press_pct;
    int                real_events;
    in_chan.valid   = 1'b0;
    in_chan.command = CMD_PRESS;
    in_chan.note    = '0;
    rst_n           = 1'b0;
    held_num        = 0;
    error_count     = 0;
    events_sent     = 0;
    results_checked = 0;
    full_drops      = 0;
    ignored_events  = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_req        = 1'b0;
    press_pct       = 55;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_key_event(DIRECTED[i].cmd, DIRECTED[i].note, DIRECTED[i].fixed, DIRECTED[i].want);
    end

    // Long receiver hold-off while events keep coming, so the input backs up.
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_key_event(CMD_PRESS, NOTE_W'($urandom_range(23)), 1'b0, ANY_VIEW);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      real_events = 0;
      while (real_events < RANDOM_EVENTS_PER_PHASE) begin
        // Swing the press rate so the stack sweeps between empty and full.
        if (events_sent % 50 == 0) press_pct = $urandom_range(80, 35);
        r = $urandom_range(99);
        if (r < 8) begin
          cmd  = cmd_e'($urandom_range(1));
          note = NOTE_W'($urandom_range(31, 24));
        end else if (held_num == 0 || r < press_pct) begin
          cmd  = CMD_PRESS;
          note = NOTE_W'($urandom_range(23));
        end else if ($urandom_range(9) < 8) begin
          cmd  = CMD_RELEASE;
          note = held_stack[$urandom_range(held_num - 1)];
        end else begin
          cmd  = CMD_RELEASE;
          note = NOTE_W'($urandom_range(31));
        end
        if (note < NOTE_LIMIT) real_events++;
        send_key_event(cmd, note, 1'b0, ANY_VIEW);
      end
    end

    in_chan.valid <= 1'b0;
    stall_pct = 0;
    while (expected_views.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d key events (%0d with no effect) and checked %0d result beats.",
             events_sent, ignored_events, results_checked);
    $display("Presses into a full stack: %0d; idle and stall phases plus one long hold-off.",
             full_drops);
    if (error_count == 0 && expected_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d results still expected.", expected_views.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lnps_pkg.sv
design/lnps_in_if.sv
design/lnps_out_if.sv
design/last_note_priority_stack_core.sv
verif/last_note_priority_stack_core_tb.sv
